// ===== design/lsr_pkg.sv =====
// shared constants and types for the line segment rasterizer
package lsr_pkg;

   localparam int LSR_COORD_BITS = 10;
   localparam int LSR_COLOR_BITS = 16;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_TICK  = 1'b1
   } lsr_action_type;

endpackage

// ===== design/lsr_if.sv =====
// request and response channel interfaces of the line segment rasterizer
interface lsr_req_if
   import lsr_pkg::*;
#(
   parameter int COORD_BITS = LSR_COORD_BITS
);
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [COORD_BITS-1:0]     start_x;
   logic [COORD_BITS-1:0]     start_y;
   logic [COORD_BITS-1:0]     end_x;
   logic [COORD_BITS-1:0]     end_y;
   logic [LSR_COLOR_BITS-1:0] draw_color;

   modport source (output valid, action, start_x, start_y, end_x, end_y, draw_color,
                   input ready);
   modport sink   (input valid, action, start_x, start_y, end_x, end_y, draw_color,
                   output ready);
endinterface

interface lsr_rsp_if
   import lsr_pkg::*;
#(
   parameter int COORD_BITS = LSR_COORD_BITS
);
   logic                      valid;
   logic                      ready;
   logic [COORD_BITS-1:0]     pixel_x;
   logic [COORD_BITS-1:0]     pixel_y;
   logic [LSR_COLOR_BITS-1:0] pixel_color;
   logic                      last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   output ready);
endinterface

// ===== design/lsr_setup.sv =====
// segment setup: steepness, axis swap, endpoint ordering and deltas
module lsr_setup
   import lsr_pkg::*;
#(
   parameter int COORD_BITS = LSR_COORD_BITS
) (
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   output logic                  is_steep,
   output logic [COORD_BITS-1:0] major_pos,
   output logic [COORD_BITS-1:0] minor_pos,
   output logic [COORD_BITS-1:0] major_end,
   output logic [COORD_BITS-1:0] major_delta,
   output logic [COORD_BITS-1:0] minor_delta,
   output logic                  minor_down
);

   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic [COORD_BITS-1:0] a_maj;
   logic [COORD_BITS-1:0] a_min;
   logic [COORD_BITS-1:0] b_maj;
   logic [COORD_BITS-1:0] b_min;
   logic [COORD_BITS-1:0] lo_maj;
   logic [COORD_BITS-1:0] lo_min;
   logic [COORD_BITS-1:0] hi_maj;
   logic [COORD_BITS-1:0] hi_min;

   always_comb begin
      dx = (start_x >= end_x) ? (start_x - end_x) : (end_x - start_x);
      dy = (start_y >= end_y) ? (start_y - end_y) : (end_y - start_y);
      is_steep = (dy > dx);

      if (is_steep) begin
         a_maj = start_y;
         a_min = start_x;
         b_maj = end_y;
         b_min = end_x;
      end else begin
         a_maj = start_x;
         a_min = start_y;
         b_maj = end_x;
         b_min = end_y;
      end

      // walk always runs up the major axis
      if (a_maj > b_maj) begin
         lo_maj = b_maj;
         lo_min = b_min;
         hi_maj = a_maj;
         hi_min = a_min;
      end else begin
         lo_maj = a_maj;
         lo_min = a_min;
         hi_maj = b_maj;
         hi_min = b_min;
      end

      major_pos   = lo_maj;
      minor_pos   = lo_min;
      major_end   = hi_maj;
      major_delta = hi_maj - lo_maj;
      minor_delta = (lo_min >= hi_min) ? (lo_min - hi_min) : (hi_min - lo_min);
      minor_down  = !(lo_min < hi_min);
   end

endmodule

// ===== design/line_segment_rasterizer.sv =====
// Bresenham line rasterizer: a start transaction (action 0) loads two endpoints and a
// colour and gives no pixel; each tick transaction (action 1) while a segment is active
// gives one pixel, with last_pixel high on the final one, after which ticks give nothing
// until the next start. One transaction is taken every clock: all setup and error-update
// work sits in one stage between the request port and the segment state and response
// registers, so a pixel reaches the response port in the cycle after its tick. The request
// side stalls only while a response is held unaccepted; a start overrides a running segment.
module line_segment_rasterizer
   import lsr_pkg::*;
#(
   parameter int COORD_BITS = LSR_COORD_BITS
) (
   input  logic     clock,
   input  logic     reset,
   lsr_req_if.sink   req_chan,
   lsr_rsp_if.source rsp_chan
);

   localparam int ErrBits = COORD_BITS + 2;

   // setup results
   logic                  su_steep;
   logic [COORD_BITS-1:0] su_major_pos;
   logic [COORD_BITS-1:0] su_minor_pos;
   logic [COORD_BITS-1:0] su_major_end;
   logic [COORD_BITS-1:0] su_major_delta;
   logic [COORD_BITS-1:0] su_minor_delta;
   logic                  su_minor_down;

   // segment state
   logic                      busy_ff, busy_in;
   logic                      steep_ff, steep_in;
   logic [COORD_BITS-1:0]     major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]     minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]     major_end_ff, major_end_in;
   logic [COORD_BITS-1:0]     major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0]     minor_delta_ff, minor_delta_in;
   logic signed [ErrBits-1:0] error_ff, error_in;
   logic                      minor_down_ff, minor_down_in;
   logic [LSR_COLOR_BITS-1:0] color_ff, color_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]     rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0]     rsp_y_ff, rsp_y_in;
   logic [LSR_COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      req_ready;
   logic                      req_accept;
   logic                      is_start;
   logic                      tick_fire;
   logic                      last;
   logic signed [ErrBits-1:0] err_sub;

   lsr_setup #(
      .COORD_BITS(COORD_BITS)
   ) u_setup (
      .start_x     (req_chan.start_x),
      .start_y     (req_chan.start_y),
      .end_x       (req_chan.end_x),
      .end_y       (req_chan.end_y),
      .is_steep    (su_steep),
      .major_pos   (su_major_pos),
      .minor_pos   (su_minor_pos),
      .major_end   (su_major_end),
      .major_delta (su_major_delta),
      .minor_delta (su_minor_delta),
      .minor_down  (su_minor_down)
   );

   assign req_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept      = req_chan.valid && req_ready;
   assign req_chan.ready  = req_ready;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_color = rsp_color_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

   always_comb begin
      is_start  = req_accept && (req_chan.action == ACT_START);
      tick_fire = req_accept && (req_chan.action == ACT_TICK) && busy_ff;
      last      = (major_pos_ff == major_end_ff);
      err_sub   = error_ff - $signed({2'b00, minor_delta_ff});

      busy_in        = busy_ff;
      steep_in       = steep_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_in       = error_ff;
      minor_down_in  = minor_down_ff;
      color_in       = color_ff;

      if (is_start) begin
         busy_in        = 1'b1;
         steep_in       = su_steep;
         major_pos_in   = su_major_pos;
         minor_pos_in   = su_minor_pos;
         major_end_in   = su_major_end;
         major_delta_in = su_major_delta;
         minor_delta_in = su_minor_delta;
         error_in       = $signed({3'b000, su_major_delta[COORD_BITS-1:1]});
         minor_down_in  = su_minor_down;
         color_in       = req_chan.draw_color;
      end else if (tick_fire) begin
         if (err_sub < 0) begin
            minor_pos_in = minor_down_ff ? (minor_pos_ff - 1'b1) : (minor_pos_ff + 1'b1);
            error_in     = err_sub + $signed({2'b00, major_delta_ff});
         end else begin
            error_in     = err_sub;
         end
         major_pos_in = major_pos_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end

      // response register: load on a pixel, drop when taken
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (req_accept) begin
         rsp_valid_in = tick_fire;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (tick_fire) begin
         rsp_x_in     = steep_ff ? minor_pos_ff : major_pos_ff;
         rsp_y_in     = steep_ff ? major_pos_ff : minor_pos_ff;
         rsp_color_in = color_ff;
         rsp_last_in  = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff       <= steep_in;
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      major_end_ff   <= major_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      error_ff       <= error_in;
      minor_down_ff  <= minor_down_in;
      color_ff       <= color_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

// ===== design/lsr_checker.sv =====
// port-level checks for the line segment rasterizer, bound to the top level
module lsr_checker
   import lsr_pkg::*;
#(
   parameter int COORD_BITS = LSR_COORD_BITS
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_action,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COORD_BITS-1:0]     rsp_pixel_x,
   input logic [COORD_BITS-1:0]     rsp_pixel_y,
   input logic [LSR_COLOR_BITS-1:0] rsp_pixel_color,
   input logic                      rsp_last_pixel
);

   // a stalled pixel stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y)
         && $stable(rsp_pixel_color) && $stable(rsp_last_pixel))
      else $error("stalled pixel changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel valid after reset");

   // a start transaction never yields a pixel
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_START) |=> !rsp_valid)
      else $error("pixel after start transaction");

   // request side only stalls behind a held pixel
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind line_segment_rasterizer lsr_checker #(
   .COORD_BITS(COORD_BITS)
) u_lsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_action      (req_chan.action),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_x     (rsp_chan.pixel_x),
   .rsp_pixel_y     (rsp_chan.pixel_y),
   .rsp_pixel_color (rsp_chan.pixel_color),
   .rsp_last_pixel  (rsp_chan.last_pixel)
);
